FILE: sv/dbft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbft_pkg
// Shared types and constants of the detection box filter and transform.
// ----------------------------------------------------------------------------
package dbft_pkg;

  localparam int MAP_ENTRIES = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CORDIC_STEPS = 16;

  localparam logic [14:0] DEPTH_CAP = 15'd19661;
  localparam logic [30:0] SPAN_CAP = 31'd36045;
  localparam logic [6:0] SPAN_CAP_CLASS = 7'd17;
  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [26:0] CORDIC_GAIN = 27'sd10188013;

  localparam logic signed [27:0] ATAN_Q24 [0:CORDIC_STEPS-1] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
    28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
    28'sd4096, 28'sd2048, 28'sd1024, 28'sd512
  };

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_DISTANCE = 3'd0;
  localparam logic [2:0] REG_TARGET_MODE = 3'd1;
  localparam logic [2:0] REG_NEGATE_BEARING = 3'd2;
  localparam logic [2:0] REG_CAMERA_OFFSET_X = 3'd3;
  localparam logic [2:0] REG_CAMERA_OFFSET_Y = 3'd4;
  localparam logic [2:0] REG_CLASS_MAP_LOW = 3'd5;
  localparam logic [2:0] REG_CLASS_MAP_HIGH = 3'd6;

  // Target frame codes.
  localparam logic [1:0] MODE_MAP = 2'd0;
  localparam logic [1:0] MODE_ROBOT = 2'd1;

  typedef struct packed {
    logic [30:0]        max_distance;
    logic [1:0]         target_mode;
    logic               negate_bearing;
    logic signed [31:0] camera_offset_x;
    logic signed [31:0] camera_offset_y;
    logic [63:0]        class_map_low;
    logic [63:0]        class_map_high;
  } cfg_t;

  // One classified object waiting in the queue.
  typedef struct packed {
    logic               kept;
    logic               frame_end;
    logic [30:0]        range_dist;
    logic signed [16:0] angle;
    logic signed [15:0] robot_yaw;
    logic [14:0]        depth;
    logic [30:0]        span;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
  } qitem_t;

  // Payload that travels beside the trig pipeline.
  typedef struct packed {
    logic               kept;
    logic               frame_end;
    logic [30:0]        range_dist;
    logic [14:0]        depth;
    logic [30:0]        span;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic               flip_b;
    logic               flip_y;
  } pl_t;

endpackage

FILE: sv/dbft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbft_front
// Filters an incoming object and forms the queue word for the back end.
// ----------------------------------------------------------------------------
module dbft_front import dbft_pkg::*; (
  input  cfg_t               cfg,
  input  logic [6:0]         class_id,
  input  logic [7:0]         score,
  input  logic [30:0]        range_dist,
  input  logic signed [15:0] bearing,
  input  logic signed [31:0] obj_width,
  input  logic signed [31:0] obj_height,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] robot_yaw,
  input  logic               last_object,
  output qitem_t             item
);

  logic [15:0] entry [0:MAP_ENTRIES-1];
  logic        class_ok;
  logic        found;

  always_comb begin
    found = 1'b0;
    class_ok = 1'b0;
    for (int k = 0; k < MAP_ENTRIES; k++) begin
      entry[k] = (k < 4) ? cfg.class_map_low[16*(k%4) +: 16]
                         : cfg.class_map_high[16*(k%4) +: 16];
      // The lowest valid entry with a matching class decides.
      if (!found && entry[k][15] && entry[k][14:8] == class_id) begin
        found = 1'b1;
        class_ok = (score >= entry[k][7:0]);
      end
    end
  end

  always_comb begin
    item.kept = (range_dist <= cfg.max_distance) && class_ok &&
                !obj_width[31] && !obj_height[31];
    item.frame_end = last_object;
    item.range_dist = range_dist;
    item.angle = cfg.negate_bearing ? -17'(bearing) : 17'(bearing);
    item.robot_yaw = robot_yaw;
    item.depth = ($signed(obj_width) < $signed({17'd0, DEPTH_CAP})) ? obj_width[14:0]
                                                                   : DEPTH_CAP;
    item.span = (class_id == SPAN_CAP_CLASS && obj_width[30:0] > SPAN_CAP) ? SPAN_CAP
                                                                         : obj_width[30:0];
    item.robot_x = robot_x;
    item.robot_y = robot_y;
  end

endmodule

FILE: sv/dbft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbft_queue
// Short queue that decouples the front end from the back-end pipeline.
// ----------------------------------------------------------------------------
module dbft_queue import dbft_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t wdata,
  input  logic   pop,
  output qitem_t rdata,
  output logic   full,
  output logic   nonempty
);

  qitem_t            mem [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

FILE: sv/dbft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbft_back
// Pipelined CORDIC, polar conversion and frame transform with output register.
// ----------------------------------------------------------------------------
module dbft_back import dbft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  qitem_t             qdata,
  input  logic               qnonempty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kept,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic [14:0]        size_depth,
  output logic [30:0]        size_span,
  output logic               frame_end
);

  logic en;
  assign en = !(out_valid && out_stall);
  assign pop = en && qnonempty;

  // CORDIC stages: index 0 holds the folded start values.
  logic               cv [0:CORDIC_STEPS];
  pl_t                cp [0:CORDIC_STEPS];
  logic signed [26:0] bx [0:CORDIC_STEPS];
  logic signed [26:0] by [0:CORDIC_STEPS];
  logic signed [27:0] bz [0:CORDIC_STEPS];
  logic signed [26:0] yx [0:CORDIC_STEPS];
  logic signed [26:0] yy [0:CORDIC_STEPS];
  logic signed [27:0] yz [0:CORDIC_STEPS];

  logic signed [16:0] ab;
  logic signed [16:0] ay;
  logic               fb;
  logic               fy;

  always_comb begin
    ab = qdata.angle;
    fb = 1'b0;
    if (ab > HALF_PI_Q13) begin
      ab = ab - PI_Q13;
      fb = 1'b1;
    end else if (ab < -HALF_PI_Q13) begin
      ab = ab + PI_Q13;
      fb = 1'b1;
    end
    ay = 17'(qdata.robot_yaw);
    fy = 1'b0;
    if (ay > HALF_PI_Q13) begin
      ay = ay - PI_Q13;
      fy = 1'b1;
    end else if (ay < -HALF_PI_Q13) begin
      ay = ay + PI_Q13;
      fy = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= qnonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp[0].kept <= qdata.kept;
      cp[0].frame_end <= qdata.frame_end;
      cp[0].range_dist <= qdata.range_dist;
      cp[0].depth <= qdata.depth;
      cp[0].span <= qdata.span;
      cp[0].robot_x <= qdata.robot_x;
      cp[0].robot_y <= qdata.robot_y;
      cp[0].flip_b <= fb;
      cp[0].flip_y <= fy;
      bx[0] <= CORDIC_GAIN;
      by[0] <= '0;
      bz[0] <= {ab, 11'd0};
      yx[0] <= CORDIC_GAIN;
      yy[0] <= '0;
      yz[0] <= {ay, 11'd0};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cp[i+1] <= cp[i];
        if (!bz[i][27]) begin
          bx[i+1] <= bx[i] - (by[i] >>> i);
          by[i+1] <= by[i] + (bx[i] >>> i);
          bz[i+1] <= bz[i] - ATAN_Q24[i];
        end else begin
          bx[i+1] <= bx[i] + (by[i] >>> i);
          by[i+1] <= by[i] - (bx[i] >>> i);
          bz[i+1] <= bz[i] + ATAN_Q24[i];
        end
        if (!yz[i][27]) begin
          yx[i+1] <= yx[i] - (yy[i] >>> i);
          yy[i+1] <= yy[i] + (yx[i] >>> i);
          yz[i+1] <= yz[i] - ATAN_Q24[i];
        end else begin
          yx[i+1] <= yx[i] + (yy[i] >>> i);
          yy[i+1] <= yy[i] - (yx[i] >>> i);
          yz[i+1] <= yz[i] + ATAN_Q24[i];
        end
      end
    end
  end

  // Multiply stages.
  localparam logic signed [58:0] RND1 = 59'sd8388608;
  localparam logic signed [62:0] RND2 = 63'sd8388608;

  logic signed [26:0] cb;
  logic signed [26:0] sb;
  logic signed [26:0] cyw;
  logic signed [26:0] syw;

  assign cb = cp[CORDIC_STEPS].flip_b ? -bx[CORDIC_STEPS] : bx[CORDIC_STEPS];
  assign sb = cp[CORDIC_STEPS].flip_b ? -by[CORDIC_STEPS] : by[CORDIC_STEPS];
  assign cyw = cp[CORDIC_STEPS].flip_y ? -yx[CORDIC_STEPS] : yx[CORDIC_STEPS];
  assign syw = cp[CORDIC_STEPS].flip_y ? -yy[CORDIC_STEPS] : yy[CORDIC_STEPS];

  logic               v1, v2, v3;
  pl_t                p1, p2, p3;
  logic signed [58:0] rc1, rs1;
  logic signed [26:0] cy1, sy1, cy2, sy2;
  logic signed [35:0] px2, py2, px3, py3;
  logic signed [62:0] m_pc, m_ps, m_xs, m_yc;
  logic signed [58:0] rc_r, rs_r;
  logic signed [35:0] px_next, py_next;

  always_comb begin
    rc_r = (rc1 + RND1) >>> 24;
    rs_r = (rs1 + RND1) >>> 24;
    px_next = 36'(rc_r) + 36'({1'b0, p1.depth[14:1]}) + 36'(cfg.camera_offset_x);
    py_next = 36'(rs_r) + 36'(cfg.camera_offset_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= cv[CORDIC_STEPS];
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= cp[CORDIC_STEPS];
      rc1 <= $signed({1'b0, cp[CORDIC_STEPS].range_dist}) * cb;
      rs1 <= $signed({1'b0, cp[CORDIC_STEPS].range_dist}) * sb;
      cy1 <= cyw;
      sy1 <= syw;
      p2 <= p1;
      px2 <= px_next;
      py2 <= py_next;
      cy2 <= cy1;
      sy2 <= sy1;
      p3 <= p2;
      px3 <= px2;
      py3 <= py2;
      m_pc <= px2 * cy2;
      m_ps <= py2 * sy2;
      m_xs <= px2 * sy2;
      m_yc <= py2 * cy2;
    end
  end

  // Final sum, frame select and saturation.
  localparam logic signed [40:0] SMAX = 41'sd2147483647;
  localparam logic signed [40:0] SMIN = -41'sd2147483648;

  logic signed [62:0] r_pc, r_ps, r_xs, r_yc;
  logic signed [40:0] mx, my, sx, sy;

  always_comb begin
    r_pc = (m_pc + RND2) >>> 24;
    r_ps = (m_ps + RND2) >>> 24;
    r_xs = (m_xs + RND2) >>> 24;
    r_yc = (m_yc + RND2) >>> 24;
    mx = 41'(r_pc) - 41'(r_ps) + 41'(p3.robot_x);
    my = 41'(r_xs) + 41'(r_yc) + 41'(p3.robot_y);
    case (cfg.target_mode)
      MODE_MAP: begin
        sx = mx;
        sy = my;
      end
      MODE_ROBOT: begin
        sx = 41'(px3);
        sy = 41'(py3);
      end
      default: begin
        sx = '0;
        sy = '0;
      end
    endcase
    if (!p3.kept) begin
      sx = '0;
      sy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kept <= p3.kept;
      frame_end <= p3.frame_end;
      size_depth <= p3.kept ? p3.depth : '0;
      size_span <= p3.kept ? p3.span : '0;
      center_x <= (sx > SMAX) ? 32'sh7fffffff : (sx < SMIN) ? 32'sh80000000 : 32'(sx);
      center_y <= (sy > SMAX) ? 32'sh7fffffff : (sy < SMIN) ? 32'sh80000000 : 32'(sy);
    end
  end

endmodule

FILE: sv/detection_box_filter_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_filter_transform
// Filters detected objects and turns kept ones into boxes in a chosen frame.
// ----------------------------------------------------------------------------
// Usage:
//   One input word per detected object arrives on the in_valid / in_stall
//   channel; exactly one output word per object leaves on out_valid /
//   out_stall, in order. A word moves when valid is high and stall is low.
//   Dropped objects give kept = 0 and zero geometry, frame_end still copied.
//   Configuration is written through cfg_we / cfg_index / cfg_data while the
//   block is idle; indexes beyond the register list are ignored.
//   Throughput is one word per cycle when the output is not stalled; the
//   back-end pipeline runs a 16-step CORDIC for both angles in parallel,
//   then three multiply stages. From input accept to output valid, a word
//   passes the fold stage that reads the queue, 16 CORDIC stages, three
//   multiply stages and the output register.
//   When the receiver stalls, the whole back-end pipeline holds; the
//   four-word queue keeps taking input until it is full, then in_stall rises.
//   Reset clears the queue and all pipeline valid bits and loads the
//   register reset values (robot frame, empty class map, max distance 0).
// ----------------------------------------------------------------------------
module detection_box_filter_transform import dbft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [6:0]         class_id,
  input  logic [7:0]         score,
  input  logic [30:0]        range_dist,
  input  logic signed [15:0] bearing,
  input  logic signed [31:0] obj_width,
  input  logic signed [31:0] obj_height,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] robot_yaw,
  input  logic               last_object,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kept,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic [14:0]        size_depth,
  output logic [30:0]        size_span,
  output logic               frame_end
);

  cfg_t   cfg;
  qitem_t fitem;
  qitem_t qdata;
  logic   qfull;
  logic   qnonempty;
  logic   pop;
  logic   push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_distance <= '0;
      cfg.target_mode <= MODE_ROBOT;
      cfg.negate_bearing <= 1'b0;
      cfg.camera_offset_x <= '0;
      cfg.camera_offset_y <= '0;
      cfg.class_map_low <= '0;
      cfg.class_map_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DISTANCE:    cfg.max_distance <= cfg_data[30:0];
        REG_TARGET_MODE:     cfg.target_mode <= cfg_data[1:0];
        REG_NEGATE_BEARING:  cfg.negate_bearing <= cfg_data[0];
        REG_CAMERA_OFFSET_X: cfg.camera_offset_x <= cfg_data[31:0];
        REG_CAMERA_OFFSET_Y: cfg.camera_offset_y <= cfg_data[31:0];
        REG_CLASS_MAP_LOW:   cfg.class_map_low <= cfg_data;
        REG_CLASS_MAP_HIGH:  cfg.class_map_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end accepts a word whenever the queue has room.
  assign in_stall = qfull;
  assign push = in_valid && !qfull;

  dbft_front u_front (
    .cfg         (cfg),
    .class_id    (class_id),
    .score       (score),
    .range_dist  (range_dist),
    .bearing     (bearing),
    .obj_width   (obj_width),
    .obj_height  (obj_height),
    .robot_x     (robot_x),
    .robot_y     (robot_y),
    .robot_yaw   (robot_yaw),
    .last_object (last_object),
    .item        (fitem)
  );

  dbft_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (fitem),
    .pop      (pop),
    .rdata    (qdata),
    .full     (qfull),
    .nonempty (qnonempty)
  );

  dbft_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .qdata      (qdata),
    .qnonempty  (qnonempty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kept       (kept),
    .center_x   (center_x),
    .center_y   (center_y),
    .size_depth (size_depth),
    .size_span  (size_span),
    .frame_end  (frame_end)
  );

  // A dropped object carries no geometry.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kept |-> center_x == 0 && center_y == 0 && size_depth == 0
      && size_span == 0)
    else $error("dropped object with nonzero geometry");

  // The box depth never exceeds its cap.
  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> size_depth <= DEPTH_CAP)
    else $error("box depth above cap");

  // The queue only pops when the back end advances and has data.
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    pop |-> qnonempty && !(out_valid && out_stall))
    else $error("queue popped while back end held");

endmodule
